/* rtl/core/sbc_pkg.sv */
package sbc_pkg;

    localparam int NUM_STATIONS = 16;
    localparam int IDX_W        = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;
    localparam int NCNT_W       = $clog2(NUM_STATIONS + 1);

    localparam int BO_W   = 11;
    localparam int WIN_W  = 10;
    localparam int DUR_W  = 11;
    localparam int TOT_W  = 32;
    localparam int GEN_W  = 32;
    localparam int DRAW_W = 16;

    // serial divider geometry
    localparam int DIV_N_W   = DRAW_W;
    localparam int DIV_D_W   = WIN_W;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    localparam logic [GEN_W-1:0] LFSR_TOGGLE = 32'h8020_0003;

    // register reset values
    localparam logic [4:0]       RST_ACTIVE_STATIONS  = 5'd1;
    localparam logic [WIN_W-1:0] RST_INITIAL_WINDOW   = 10'd31;
    localparam logic [WIN_W-1:0] RST_MAX_WINDOW       = 10'd1023;
    localparam logic [9:0]       RST_FRAME_OVERHEAD   = 10'd40;
    localparam logic [9:0]       RST_PAYLOAD_RANGE    = 10'd66;
    localparam logic [7:0]       RST_DURATION_DIVISOR = 8'd12;
    localparam logic [GEN_W-1:0] RST_RANDOM_SEED      = 32'd1;

    typedef enum logic [2:0] {
        REG_ACTIVE_STATIONS,
        REG_INITIAL_WINDOW,
        REG_MAX_WINDOW,
        REG_FRAME_OVERHEAD,
        REG_PAYLOAD_RANGE,
        REG_DURATION_DIVISOR,
        REG_RANDOM_SEED
    } reg_index_t;

    typedef struct packed {
        logic             sending;
        logic [BO_W-1:0]  backoff;
        logic [WIN_W-1:0] window;
    } station_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RST_DRAW,
        S_RST_WAIT,
        S_CNT_RD,
        S_CNT_EV,
        S_RDR_RD,
        S_RDR_EV,
        S_RDR_WAIT,
        S_SLOT,
        S_REL_RD,
        S_REL_EV,
        S_REL_WAIT,
        S_SEL_RD,
        S_SEL_EV,
        S_SEL_MOD,
        S_SEL_DUR,
        S_FIN
    } state_t;

    function automatic logic [GEN_W-1:0] lfsr_step(input logic [GEN_W-1:0] g);
        logic [GEN_W-1:0] s;
        s = g >> 1;
        if (g[0])
        begin
            s = s ^ LFSR_TOGGLE;
        end
        return s;
    endfunction

endpackage

/* rtl/core/sbc_if.sv */
interface sbc_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface sbc_result_if;
    logic        valid;
    logic        ready;
    logic        collision;
    logic        send_started;
    logic [3:0]  sender_index;
    logic [10:0] send_duration;
    logic        channel_idle;
    logic [31:0] collision_total;
    logic [31:0] success_total;
    logic [31:0] busy_total;

    modport source (output valid, output collision, output send_started,
                    output sender_index, output send_duration, output channel_idle,
                    output collision_total, output success_total, output busy_total,
                    input ready);
    modport sink   (input valid, input collision, input send_started,
                    input sender_index, input send_duration, input channel_idle,
                    input collision_total, input success_total, input busy_total,
                    output ready);
endinterface

/* rtl/core/sbc_div.sv */
module sbc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sbc_pkg::DIV_N_W-1:0]   dividend,
    input  logic [sbc_pkg::DIV_D_W-1:0]   divisor,
    output logic                          done,
    output logic [sbc_pkg::DIV_N_W-1:0]   quotient,
    output logic [sbc_pkg::DIV_D_W-1:0]   remainder
);

    logic [sbc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          done_reg;
    logic [sbc_pkg::DIV_N_W-1:0]   quo_reg;
    logic [sbc_pkg::DIV_D_W-1:0]   rem_reg;
    logic [sbc_pkg::DIV_D_W-1:0]   dvs_reg;
    logic [sbc_pkg::DIV_D_W:0]     trial;
    logic [sbc_pkg::DIV_D_W:0]     diff;
    logic                          fits;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        trial = {rem_reg, quo_reg[sbc_pkg::DIV_N_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = trial >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == sbc_pkg::DIV_CNT_W'(1)) && !start;
            if (start)
            begin
                cnt_reg <= sbc_pkg::DIV_CNT_W'(sbc_pkg::DIV_N_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - sbc_pkg::DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? diff[sbc_pkg::DIV_D_W-1:0] : trial[sbc_pkg::DIV_D_W-1:0];
            quo_reg <= {quo_reg[sbc_pkg::DIV_N_W-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    // modulo by zero yields zero
    assign remainder = (dvs_reg == '0) ? '0 : rem_reg;

endmodule

/* rtl/core/sbc_ram.sv */
module sbc_ram (
    input  logic                            clk,
    input  logic                            we,
    input  logic [sbc_pkg::IDX_W-1:0]       waddr,
    input  sbc_pkg::station_t               wdata,
    input  logic [sbc_pkg::IDX_W-1:0]       raddr,
    output sbc_pkg::station_t               rdata
);

    sbc_pkg::station_t mem [sbc_pkg::NUM_STATIONS];
    sbc_pkg::station_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/slotted_backoff_contention.sv */
// Sequencing: a restart draws one backoff per active station; a slot tick runs a
// countdown sweep over the stations, then one 16-step serial division per redraw,
// per release and per selection draw or duration.
// Throughput: one transaction at a time; the next tick is taken once the sequencer is idle.
// Reset: clears control, totals, channel and generator (seed one); the station
// table holds nothing until the first restart tick.
module slotted_backoff_contention (
    input  logic                 clk,
    input  logic                 rst_n,
    sbc_tick_if.sink             tick,
    sbc_result_if.source         result,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam logic [1:0] NREQ_NONE = 2'd0;
    localparam logic [1:0] NREQ_ONE  = 2'd1;
    localparam logic [1:0] NREQ_MANY = 2'd2;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [4:0]                     cnt_cfg_reg;
    logic [sbc_pkg::WIN_W-1:0]      init_win_reg;
    logic [sbc_pkg::WIN_W-1:0]      max_win_reg;
    logic [9:0]                     overhead_reg;
    logic [9:0]                     prange_reg;
    logic [7:0]                     divisor_reg;
    logic [sbc_pkg::GEN_W-1:0]      seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_cfg_reg  <= sbc_pkg::RST_ACTIVE_STATIONS;
            init_win_reg <= sbc_pkg::RST_INITIAL_WINDOW;
            max_win_reg  <= sbc_pkg::RST_MAX_WINDOW;
            overhead_reg <= sbc_pkg::RST_FRAME_OVERHEAD;
            prange_reg   <= sbc_pkg::RST_PAYLOAD_RANGE;
            divisor_reg  <= sbc_pkg::RST_DURATION_DIVISOR;
            seed_reg     <= sbc_pkg::RST_RANDOM_SEED;
        end
        else if (cfg_we)
        begin
            case (sbc_pkg::reg_index_t'(cfg_index))
                sbc_pkg::REG_ACTIVE_STATIONS:  cnt_cfg_reg  <= cfg_data[4:0];
                sbc_pkg::REG_INITIAL_WINDOW:   init_win_reg <= cfg_data[9:0];
                sbc_pkg::REG_MAX_WINDOW:       max_win_reg  <= cfg_data[9:0];
                sbc_pkg::REG_FRAME_OVERHEAD:   overhead_reg <= cfg_data[9:0];
                sbc_pkg::REG_PAYLOAD_RANGE:    prange_reg   <= cfg_data[9:0];
                sbc_pkg::REG_DURATION_DIVISOR: divisor_reg  <= cfg_data[7:0];
                sbc_pkg::REG_RANDOM_SEED:      seed_reg     <= cfg_data;
                default:                       ; // index beyond the list: drop
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and per-tick state
    // ------------------------------------------------------------------
    sbc_pkg::state_t                    state_reg, state_next;
    logic [sbc_pkg::IDX_W-1:0]          idx_reg, idx_next;
    logic [sbc_pkg::GEN_W-1:0]          gen_reg, gen_next;
    logic                               busy_reg, busy_next;
    logic [sbc_pkg::DUR_W-1:0]          slots_reg, slots_next;
    logic [sbc_pkg::TOT_W-1:0]          coll_tot_reg, coll_tot_next;
    logic [sbc_pkg::TOT_W-1:0]          succ_tot_reg, succ_tot_next;
    logic [sbc_pkg::TOT_W-1:0]          busy_tot_reg, busy_tot_next;
    logic [sbc_pkg::NUM_STATIONS-1:0]   req_reg, req_next;
    logic [1:0]                         nreq_reg, nreq_next;
    logic                               coll_reg, coll_next;
    logic                               started_reg, started_next;
    logic [3:0]                         sender_reg, sender_next;
    logic [sbc_pkg::DUR_W-1:0]          dur_reg, dur_next;
    sbc_pkg::station_t                  ent_reg, ent_next;

    logic                               out_valid_reg, out_valid_next;
    logic                               o_coll_reg, o_started_reg, o_idle_reg;
    logic [3:0]                         o_sender_reg;
    logic [sbc_pkg::DUR_W-1:0]          o_dur_reg;
    logic [sbc_pkg::TOT_W-1:0]          o_coll_tot_reg, o_succ_tot_reg, o_busy_tot_reg;

    // station table
    logic                               ram_we;
    sbc_pkg::station_t                  ram_wdata;
    sbc_pkg::station_t                  rd;

    sbc_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (rd)
    );

    // shared modulo / duration divider
    logic                               div_start;
    logic [sbc_pkg::DIV_N_W-1:0]        div_dividend;
    logic [sbc_pkg::DIV_D_W-1:0]        div_divisor;
    logic                               div_done;
    logic [sbc_pkg::DIV_N_W-1:0]        div_quo;
    logic [sbc_pkg::DIV_D_W-1:0]        div_rem;

    sbc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // ------------------------------------------------------------------
    // Shared decode
    // ------------------------------------------------------------------
    logic                               in_acc;
    logic                               out_free;
    logic [sbc_pkg::NCNT_W-1:0]         n_act;
    logic                               no_sta;
    logic                               is_last;
    logic [sbc_pkg::GEN_W-1:0]          gen_step;
    logic [sbc_pkg::DRAW_W-1:0]         draw_val;
    logic [sbc_pkg::BO_W-1:0]           dec_bo;
    logic                               req_hit;
    logic [1:0]                         nreq_upd;
    logic                               coll_now;
    logic                               redraw_now;
    logic [sbc_pkg::WIN_W:0]            grow;
    logic [sbc_pkg::WIN_W-1:0]          grown_w;
    logic                               eligible;
    logic                               release_now;
    logic                               fin_ent;
    logic [sbc_pkg::DUR_W-1:0]          raw_time;
    logic [sbc_pkg::DUR_W-1:0]          dur_val;
    logic [sbc_pkg::TOT_W:0]            coll_sum, succ_sum, busy_sum;

    always_comb
    begin
        in_acc   = tick.valid && tick.ready;
        out_free = !out_valid_reg || result.ready;

        // a count above the table size acts as the table size
        if (int'(cnt_cfg_reg) > sbc_pkg::NUM_STATIONS)
        begin
            n_act = sbc_pkg::NCNT_W'(sbc_pkg::NUM_STATIONS);
        end
        else
        begin
            n_act = sbc_pkg::NCNT_W'(cnt_cfg_reg);
        end
        no_sta  = (n_act == '0);
        is_last = (idx_reg == sbc_pkg::IDX_W'(n_act - sbc_pkg::NCNT_W'(1)));

        gen_step = sbc_pkg::lfsr_step(gen_reg);
        draw_val = gen_step[sbc_pkg::DRAW_W-1:0];

        // countdown sweep: a non-sending station steps toward zero
        dec_bo   = (rd.backoff == '0) ? '0 : rd.backoff - sbc_pkg::BO_W'(1);
        req_hit  = !rd.sending && (dec_bo == '0);
        nreq_upd = nreq_reg;
        if (req_hit && nreq_reg == NREQ_NONE)
        begin
            nreq_upd = NREQ_ONE;
        end
        else if (req_hit)
        begin
            nreq_upd = NREQ_MANY;
        end
        coll_now   = (nreq_upd == NREQ_MANY) && !busy_reg;
        redraw_now = (nreq_upd != NREQ_NONE) && busy_reg;

        // collision growth: 2w+1, capped
        grow    = {rd.window, 1'b1};
        grown_w = (grow > {1'b0, max_win_reg}) ? max_win_reg : grow[sbc_pkg::WIN_W-1:0];

        eligible    = !rd.sending && (rd.backoff == '0);
        release_now = (slots_reg == sbc_pkg::DUR_W'(1));

        raw_time = {1'b0, overhead_reg} + {1'b0, div_rem};
        dur_val  = div_quo[sbc_pkg::DUR_W-1:0];

        coll_sum = {1'b0, coll_tot_reg} + (sbc_pkg::TOT_W + 1)'(1);
        succ_sum = {1'b0, succ_tot_reg} + (sbc_pkg::TOT_W + 1)'(1);
        busy_sum = {1'b0, busy_tot_reg} + (sbc_pkg::TOT_W + 1)'(dur_val);

        // the current station entry is finished and the sweep may move on
        case (state_reg)
            sbc_pkg::S_RST_WAIT: fin_ent = div_done;
            sbc_pkg::S_CNT_EV:   fin_ent = 1'b1;
            sbc_pkg::S_RDR_RD:   fin_ent = !req_reg[idx_reg];
            sbc_pkg::S_RDR_WAIT: fin_ent = div_done;
            sbc_pkg::S_REL_EV:   fin_ent = !rd.sending;
            sbc_pkg::S_REL_WAIT: fin_ent = div_done;
            sbc_pkg::S_SEL_EV:   fin_ent = !eligible;
            default:             fin_ent = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sbc_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    if (tick.restart)
                    begin
                        state_next = no_sta ? sbc_pkg::S_FIN : sbc_pkg::S_RST_DRAW;
                    end
                    else
                    begin
                        state_next = no_sta ? sbc_pkg::S_SLOT : sbc_pkg::S_CNT_RD;
                    end
                end
            end
            sbc_pkg::S_RST_DRAW:
            begin
                state_next = sbc_pkg::S_RST_WAIT;
            end
            sbc_pkg::S_RST_WAIT:
            begin
                if (div_done)
                begin
                    state_next = is_last ? sbc_pkg::S_FIN : sbc_pkg::S_RST_DRAW;
                end
            end
            sbc_pkg::S_CNT_RD:
            begin
                state_next = sbc_pkg::S_CNT_EV;
            end
            sbc_pkg::S_CNT_EV:
            begin
                if (!is_last)
                begin
                    state_next = sbc_pkg::S_CNT_RD;
                end
                else if (coll_now || redraw_now)
                begin
                    state_next = sbc_pkg::S_RDR_RD;
                end
                else
                begin
                    state_next = sbc_pkg::S_SLOT;
                end
            end
            sbc_pkg::S_RDR_RD:
            begin
                if (req_reg[idx_reg])
                begin
                    state_next = sbc_pkg::S_RDR_EV;
                end
                else if (is_last)
                begin
                    state_next = sbc_pkg::S_SLOT;
                end
            end
            sbc_pkg::S_RDR_EV:
            begin
                state_next = sbc_pkg::S_RDR_WAIT;
            end
            sbc_pkg::S_RDR_WAIT:
            begin
                if (div_done)
                begin
                    state_next = is_last ? sbc_pkg::S_SLOT : sbc_pkg::S_RDR_RD;
                end
            end
            sbc_pkg::S_SLOT:
            begin
                if (release_now && !no_sta)
                begin
                    state_next = sbc_pkg::S_REL_RD;
                end
                else if (coll_reg || no_sta)
                begin
                    state_next = sbc_pkg::S_FIN;
                end
                else
                begin
                    state_next = sbc_pkg::S_SEL_RD;
                end
            end
            sbc_pkg::S_REL_RD:
            begin
                state_next = sbc_pkg::S_REL_EV;
            end
            sbc_pkg::S_REL_EV, sbc_pkg::S_REL_WAIT:
            begin
                if (state_reg == sbc_pkg::S_REL_EV && rd.sending)
                begin
                    state_next = sbc_pkg::S_REL_WAIT;
                end
                else if (fin_ent && !is_last)
                begin
                    state_next = sbc_pkg::S_REL_RD;
                end
                else if (fin_ent)
                begin
                    state_next = coll_reg ? sbc_pkg::S_FIN : sbc_pkg::S_SEL_RD;
                end
            end
            sbc_pkg::S_SEL_RD:
            begin
                state_next = sbc_pkg::S_SEL_EV;
            end
            sbc_pkg::S_SEL_EV:
            begin
                if (eligible)
                begin
                    state_next = sbc_pkg::S_SEL_MOD;
                end
                else
                begin
                    state_next = is_last ? sbc_pkg::S_FIN : sbc_pkg::S_SEL_RD;
                end
            end
            sbc_pkg::S_SEL_MOD:
            begin
                if (div_done)
                begin
                    state_next = busy_reg ? sbc_pkg::S_FIN : sbc_pkg::S_SEL_DUR;
                end
            end
            sbc_pkg::S_SEL_DUR:
            begin
                if (div_done)
                begin
                    state_next = sbc_pkg::S_FIN;
                end
            end
            sbc_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    state_next = sbc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sbc_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath, table writes and divider requests
    // ------------------------------------------------------------------
    always_comb
    begin
        idx_next      = idx_reg;
        gen_next      = gen_reg;
        busy_next     = busy_reg;
        slots_next    = slots_reg;
        coll_tot_next = coll_tot_reg;
        succ_tot_next = succ_tot_reg;
        busy_tot_next = busy_tot_reg;
        req_next      = req_reg;
        nreq_next     = nreq_reg;
        coll_next     = coll_reg;
        started_next  = started_reg;
        sender_next   = sender_reg;
        dur_next      = dur_reg;
        ent_next      = ent_reg;
        ram_we        = 1'b0;
        ram_wdata     = rd;
        div_start     = 1'b0;
        div_dividend  = draw_val;
        div_divisor   = rd.window;

        // advance the sweep index; wrap to the first station at the end of a sweep
        if (fin_ent)
        begin
            idx_next = is_last ? '0 : idx_reg + sbc_pkg::IDX_W'(1);
        end

        case (state_reg)
            sbc_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    idx_next     = '0;
                    req_next     = '0;
                    nreq_next    = NREQ_NONE;
                    coll_next    = 1'b0;
                    started_next = 1'b0;
                    sender_next  = '0;
                    dur_next     = '0;
                    if (tick.restart)
                    begin
                        gen_next      = seed_reg;
                        busy_next     = 1'b0;
                        slots_next    = '0;
                        coll_tot_next = '0;
                        succ_tot_next = '0;
                        busy_tot_next = '0;
                    end
                end
            end
            sbc_pkg::S_RST_DRAW:
            begin
                gen_next    = gen_step;
                div_start   = 1'b1;
                div_divisor = init_win_reg;
            end
            sbc_pkg::S_RST_WAIT:
            begin
                if (div_done)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = '{sending: 1'b0,
                                  backoff: {1'b0, div_rem} + sbc_pkg::BO_W'(1),
                                  window:  init_win_reg};
                end
            end
            sbc_pkg::S_CNT_EV:
            begin
                if (!rd.sending)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = '{sending: rd.sending, backoff: dec_bo, window: rd.window};
                end
                if (req_hit)
                begin
                    req_next[idx_reg] = 1'b1;
                end
                nreq_next = nreq_upd;
                if (is_last && coll_now)
                begin
                    coll_next     = 1'b1;
                    coll_tot_next = coll_sum[sbc_pkg::TOT_W] ? '1 : coll_sum[sbc_pkg::TOT_W-1:0];
                end
            end
            sbc_pkg::S_RDR_EV:
            begin
                // colliders grow their window first; a busy channel keeps it
                gen_next    = gen_step;
                div_start   = 1'b1;
                div_divisor = coll_reg ? grown_w : rd.window;
                ent_next    = '{sending: rd.sending, backoff: rd.backoff,
                                window:  coll_reg ? grown_w : rd.window};
            end
            sbc_pkg::S_RDR_WAIT:
            begin
                if (div_done)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = '{sending: ent_reg.sending, backoff: {1'b0, div_rem},
                                  window:  ent_reg.window};
                end
            end
            sbc_pkg::S_SLOT:
            begin
                if (slots_reg != '0)
                begin
                    slots_next = slots_reg - sbc_pkg::DUR_W'(1);
                    if (release_now)
                    begin
                        busy_next = 1'b0;
                    end
                end
            end
            sbc_pkg::S_REL_EV:
            begin
                if (rd.sending)
                begin
                    gen_next    = gen_step;
                    div_start   = 1'b1;
                    div_divisor = init_win_reg;
                end
            end
            sbc_pkg::S_REL_WAIT:
            begin
                if (div_done)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = '{sending: 1'b0, backoff: {1'b0, div_rem},
                                  window:  init_win_reg};
                end
            end
            sbc_pkg::S_SEL_EV:
            begin
                if (eligible)
                begin
                    gen_next    = gen_step;
                    div_start   = 1'b1;
                    div_divisor = busy_reg ? rd.window : prange_reg;
                    ent_next    = rd;
                end
            end
            sbc_pkg::S_SEL_MOD:
            begin
                if (div_done)
                begin
                    if (busy_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = '{sending: ent_reg.sending, backoff: {1'b0, div_rem},
                                      window:  ent_reg.window};
                    end
                    else
                    begin
                        // raw time over the divisor; a zero divisor acts as one
                        div_start    = 1'b1;
                        div_dividend = sbc_pkg::DIV_N_W'(raw_time);
                        div_divisor  = (divisor_reg == '0) ? sbc_pkg::DIV_D_W'(1)
                                                           : sbc_pkg::DIV_D_W'(divisor_reg);
                    end
                end
            end
            sbc_pkg::S_SEL_DUR:
            begin
                if (div_done)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = '{sending: 1'b1, backoff: ent_reg.backoff,
                                  window:  ent_reg.window};
                    // a zero duration still marks the station but leaves the channel idle
                    if (dur_val != '0)
                    begin
                        busy_next     = 1'b1;
                        slots_next    = dur_val;
                        succ_tot_next = succ_sum[sbc_pkg::TOT_W] ? '1
                                                                 : succ_sum[sbc_pkg::TOT_W-1:0];
                        busy_tot_next = busy_sum[sbc_pkg::TOT_W] ? '1
                                                                 : busy_sum[sbc_pkg::TOT_W-1:0];
                        started_next  = 1'b1;
                        sender_next   = 4'(idx_reg);
                        dur_next      = dur_val;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // result register: drop after the transaction, load when the sequencer finishes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == sbc_pkg::S_FIN && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbc_pkg::S_IDLE;
            idx_reg       <= '0;
            gen_reg       <= sbc_pkg::GEN_W'(1);
            busy_reg      <= 1'b0;
            slots_reg     <= '0;
            coll_tot_reg  <= '0;
            succ_tot_reg  <= '0;
            busy_tot_reg  <= '0;
            req_reg       <= '0;
            nreq_reg      <= NREQ_NONE;
            coll_reg      <= 1'b0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            gen_reg       <= gen_next;
            busy_reg      <= busy_next;
            slots_reg     <= slots_next;
            coll_tot_reg  <= coll_tot_next;
            succ_tot_reg  <= succ_tot_next;
            busy_tot_reg  <= busy_tot_next;
            req_reg       <= req_next;
            nreq_reg      <= nreq_next;
            coll_reg      <= coll_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sender_reg <= sender_next;
        dur_reg    <= dur_next;
        ent_reg    <= ent_next;
        if (state_reg == sbc_pkg::S_FIN && out_free)
        begin
            o_coll_reg     <= coll_reg;
            o_started_reg  <= started_reg;
            o_sender_reg   <= sender_reg;
            o_dur_reg      <= dur_reg;
            o_idle_reg     <= !busy_reg;
            o_coll_tot_reg <= coll_tot_reg;
            o_succ_tot_reg <= succ_tot_reg;
            o_busy_tot_reg <= busy_tot_reg;
        end
    end

    assign tick.ready             = (state_reg == sbc_pkg::S_IDLE);
    assign result.valid           = out_valid_reg;
    assign result.collision       = o_coll_reg;
    assign result.send_started    = o_started_reg;
    assign result.sender_index    = o_sender_reg;
    assign result.send_duration   = o_dur_reg;
    assign result.channel_idle    = o_idle_reg;
    assign result.collision_total = o_coll_tot_reg;
    assign result.success_total   = o_succ_tot_reg;
    assign result.busy_total      = o_busy_tot_reg;

endmodule
